/* rtl/core/gce_pkg.sv */
// shared types and constants for the graph connectivity engine
// no dependencies
package gce_pkg;
  localparam int unsigned MaxVertices = 128;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_DEL = 3'd1,
    MODE_CYCLE = 3'd2,
    MODE_COMP = 3'd3,
    MODE_REACH = 3'd4
  } mode_t;

  localparam logic [1:0] MarkNone = 2'd0;
  localparam logic [1:0] MarkFound = 2'd1;
  localparam logic [1:0] MarkDone = 2'd2;
endpackage

/* rtl/core/gce_adj_mem.sv */
// adjacency row memory, one row per vertex, registered read
// depends on gce_pkg
module gce_adj_mem #(
  parameter int unsigned NV = gce_pkg::MaxVertices
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [$clog2(NV)-1:0] wr_addr,
  input  logic [NV-1:0]         wr_data,
  input  logic [$clog2(NV)-1:0] rd_addr,
  output logic [NV-1:0]         rd_data
);
  import gce_pkg::*;
  logic [NV-1:0] mem [NV];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/core/graph_connectivity_engine.sv */
// top level of the graph connectivity engine: command sequencer, walk logic
// depends on gce_pkg and gce_adj_mem
//
//  channel  | signals                           | transfer
//  command  | start busy mode vertex_a vertex_b | start & !busy
//  config   | cfg_valid cfg_ready vertex_count  | cfg_valid & cfg_ready
//  result   | done answer                       | done, one cycle
//
// add or delete: two row read-modify-writes, busy from S_E_RD0 through S_E_WB1
// queries: one scan step per component plus one; per popped vertex the steps pop,
//   stack read, row read, plus one step per pushed vertex; for cycle a pass of
//   S_CY_RD and S_CY_CHK per row; then S_FIN, and done follows the last busy cycle
// reach outside the range or onto itself: done the cycle after, busy stays low
// rst clears edges by a sweep over all MAX_VERTICES rows; busy stays high meanwhile
// results cannot be stalled
module graph_connectivity_engine #(
  parameter int unsigned MAX_VERTICES = gce_pkg::MaxVertices
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [6:0] vertex_a,
  input  logic [6:0] vertex_b,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] vertex_count,
  output logic       done,
  output logic [7:0] answer
);
  import gce_pkg::*;
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_E_RD0, S_E_WB0, S_E_RD1, S_E_WB1,
    S_SCAN, S_POP, S_LOAD, S_RELAX, S_CY_RD, S_CY_CHK, S_FIN
  } state_t;

  state_t          state;
  logic [7:0]      vcount;
  logic [CW-1:0]   n;
  logic [2:0]      op;
  logic [AW-1:0]   ea, eb;
  logic            eon;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   sp;
  logic [AW-1:0]   stk [MAX_VERTICES];
  logic            stk_we;
  logic [AW-1:0]   stk_wa, stk_wd, stk_ra, stk_rd;
  logic [MAX_VERTICES-1:0] found;
  logic [MAX_VERTICES-1:0] nmask;
  logic [AW-1:0]   cur;
  logic [CW-1:0]   comps;
  logic [2*CW:0]   edges;
  logic            self_loop;
  logic [MAX_VERTICES-1:0] nbr;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [MAX_VERTICES-1:0] mem_wd, mem_rd;
  logic [CW-1:0]   vc_sat;
  logic            a_ok, b_ok;
  logic            reach_go;
  logic [AW-1:0]   pick;
  logic            pick_any;
  logic [AW-1:0]   low;
  logic [MAX_VERTICES-1:0] upper;

  gce_adj_mem #(.NV(MAX_VERTICES)) u_mem (
    .clk, .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
    .rd_addr(mem_ra), .rd_data(mem_rd)
  );

  assign vc_sat = (32'(vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount);
  assign a_ok = ({1'b0, vertex_a} < 8'(MAX_VERTICES)) || (MAX_VERTICES > 128);
  assign b_ok = ({1'b0, vertex_b} < 8'(MAX_VERTICES)) || (MAX_VERTICES > 128);
  assign reach_go = (mode == MODE_REACH) && (32'(vertex_a) < 32'(vc_sat))
                    && (32'(vertex_b) < 32'(vc_sat)) && (vertex_a != vertex_b);
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (CW'(i) < n);
      upper[i] = (AW'(i) > cur);
    end
  end
  assign nbr = mem_rd & nmask & ~found;

  // first unvisited vertex at or above idx, for the component scan
  always_comb begin
    pick = '0;
    pick_any = 1'b0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (!found[i] && nmask[i] && CW'(i) >= idx) begin
        pick = AW'(i);
        pick_any = 1'b1;
      end
    end
  end

  // lowest new neighbor of the current row
  always_comb begin
    low = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (nbr[i]) low = AW'(i);
    end
  end

  // walk stack write port and read address
  always_comb begin
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = low;
    stk_ra = sp[AW-1:0] - AW'(1);
    unique case (state)
      S_IDLE: begin
        stk_we = start && reach_go;
        stk_wd = AW'(vertex_a);
      end
      S_SCAN: begin
        stk_we = pick_any;
        stk_wd = pick;
      end
      S_RELAX: begin
        stk_we = (nbr != '0);
        stk_wa = sp[AW-1:0];
        stk_wd = low;
      end
      default: stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_wa] <= stk_wd;
    end
    stk_rd <= stk[stk_ra];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ea;
    mem_wd = mem_rd;
    mem_ra = cur;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx[AW-1:0];
        mem_wd = '0;
      end
      S_E_RD0: mem_ra = ea;
      S_E_WB0: begin
        mem_we = 1'b1;
        mem_wa = ea;
        mem_wd = mem_rd;
        mem_wd[eb] = eon;
      end
      S_E_RD1: mem_ra = eb;
      S_E_WB1: begin
        mem_we = 1'b1;
        mem_wa = eb;
        mem_wd = mem_rd;
        mem_wd[ea] = eon;
      end
      S_LOAD: mem_ra = stk_rd;
      S_CY_RD: mem_ra = idx[AW-1:0];
      default: mem_ra = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      vcount <= '0;
      done <= 1'b0;
      sp <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vcount <= vertex_count;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(MAX_VERTICES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op <= mode;
            ea <= AW'(vertex_a);
            eb <= AW'(vertex_b);
            eon <= (mode == MODE_ADD);
            n <= vc_sat;
            found <= reach_go ? (MAX_VERTICES)'(1) << vertex_a : '0;
            sp <= reach_go ? CW'(1) : '0;
            comps <= '0;
            edges <= '0;
            self_loop <= 1'b0;
            idx <= '0;
            if ((mode == MODE_ADD || mode == MODE_DEL) && a_ok && b_ok) begin
              state <= S_E_RD0;
            end else if (mode == MODE_CYCLE || mode == MODE_COMP) begin
              state <= S_SCAN;
            end else if (mode == MODE_REACH) begin
              if (reach_go) begin
                state <= S_POP;
              end else begin
                answer <= '0;
                done <= 1'b1;
              end
            end
          end
        end
        S_E_RD0: state <= S_E_WB0;
        S_E_WB0: state <= S_E_RD1;
        S_E_RD1: state <= S_E_WB1;
        S_E_WB1: state <= S_IDLE;
        S_SCAN: begin
          if (pick_any) begin
            comps <= comps + CW'(1);
            found[pick] <= 1'b1;
            sp <= CW'(1);
            idx <= CW'(pick) + CW'(1);
            state <= S_POP;
          end else if (op == MODE_CYCLE) begin
            idx <= '0;
            state <= (n == '0) ? S_FIN : S_CY_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            state <= (op == MODE_REACH) ? S_FIN : S_SCAN;
          end else begin
            sp <= sp - CW'(1);
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur <= stk_rd;
          state <= S_RELAX;
        end
        S_RELAX: begin
          if (nbr == '0) begin
            state <= S_POP;
          end else begin
            found[low] <= 1'b1;
            sp <= sp + CW'(1);
          end
        end
        S_CY_RD: begin
          cur <= idx[AW-1:0];
          state <= S_CY_CHK;
        end
        S_CY_CHK: begin
          if (mem_rd[cur]) self_loop <= 1'b1;
          edges <= edges + (2*CW+1)'($countones(mem_rd & nmask & upper));
          idx <= idx + CW'(1);
          state <= (idx + CW'(1) >= n) ? S_FIN : S_CY_RD;
        end
        S_FIN: begin
          done <= 1'b1;
          unique case (op)
            MODE_CYCLE: answer <= (self_loop
                || (edges + (2*CW+1)'(comps) > (2*CW+1)'(n))) ? 8'd1 : 8'd0;
            MODE_COMP: answer <= 8'(comps);
            default: answer <= {7'd0, found[eb]};
          endcase
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_IDLE || state == S_FIN)) else $error("stray done");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(MAX_VERTICES)) else $error("stack overflow");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config while busy");
endmodule
